@@ hdl/lpr_pkg.sv @@
`timescale 1ns / 1ps

package lpr_pkg;

    // fixed field widths of the reference and result transfers and of the last-use stamps
    localparam int unsigned PAGE_W      = 16;
    localparam int unsigned FRAME_IDX_W = 6;
    localparam int unsigned STAMP_W     = 32;
    localparam int unsigned FAULT_W     = 32;

    typedef logic [PAGE_W-1:0]      page_t;
    typedef logic [FRAME_IDX_W-1:0] frame_idx_t;
    typedef logic [STAMP_W-1:0]     stamp_t;
    typedef logic [FAULT_W-1:0]     fault_t;

endpackage

@@ hdl/lru_page_replacement.sv @@
`timescale 1ns / 1ps
// a reference is accepted from idle, then the frame store is read for frames 0 to n - 1,
// where n is the number of filled frames (up to FRAMES), the last compare drains and the
// result forms; with no frame filled yet, scan and drain are skipped; a new reference is
// taken only in idle, and the frame store's single read port serves one frame per scan cycle
// reset (rst_n low, asynchronous): all frames empty, time and fault count at zero;
// results are strobed for one cycle and the receiver cannot stall them

module lru_page_replacement #(
    parameter int unsigned FRAMES = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  lpr_pkg::page_t              page,
    output logic                        busy,
    output logic                        done,
    output logic                        hit,
    output lpr_pkg::frame_idx_t         frame_index,
    output logic                        evicted_valid,
    output lpr_pkg::page_t              evicted_page,
    output lpr_pkg::fault_t             fault_total
);

    // index into the frame store, and a count that can hold FRAMES itself
    localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int unsigned CNT_W = $clog2(FRAMES + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // frame store: pages and last-use stamps, one read port and one write port
    lpr_pkg::page_t  pages_mem  [FRAMES];
    lpr_pkg::stamp_t stamps_mem [FRAMES];

    state_t          state_reg;
    lpr_pkg::page_t  page_reg;          // reference under work
    lpr_pkg::stamp_t time_reg;          // saturating time counter
    lpr_pkg::fault_t fault_reg;
    cnt_t            filled_reg;        // frames filled so far, in index order
    idx_t            issue_reg;         // frame address being read during the scan

    // compare stage, fed by the registered read port
    logic            cmp_vld_reg;
    idx_t            cmp_idx_reg;
    lpr_pkg::page_t  rd_page_reg;
    lpr_pkg::stamp_t rd_stamp_reg;

    // scan results
    logic            found_reg;
    idx_t            hit_idx_reg;
    lpr_pkg::stamp_t min_stamp_reg;
    idx_t            min_idx_reg;
    lpr_pkg::page_t  min_page_reg;

    // registered result
    logic            done_reg;
    logic            hit_reg;
    lpr_pkg::frame_idx_t frame_index_reg;
    logic            evicted_valid_reg;
    lpr_pkg::page_t  evicted_page_reg;

    lpr_pkg::stamp_t time_next;
    logic            last_issue;
    logic            full;
    logic            match;
    logic            new_min;
    idx_t            used_idx;
    logic            evict;
    logic            page_we;
    logic            finish;

    // time advances before each reference and stops at its maximum
    assign time_next  = (time_reg == '1) ? time_reg : time_reg + lpr_pkg::stamp_t'(1);

    // the scan covers frames 0 to filled - 1
    assign last_issue = ((cnt_t'(issue_reg) + cnt_t'(1)) == filled_reg);
    assign full       = (filled_reg == cnt_t'(FRAMES));

    // first matching frame wins; strict less-than keeps the lowest index on ties
    assign match   = cmp_vld_reg && !found_reg && (rd_page_reg == page_reg);
    assign new_min = cmp_vld_reg && ((cmp_idx_reg == '0) || (rd_stamp_reg < min_stamp_reg));

    assign finish  = (state_reg == ST_FINISH);

    // choose the frame that this reference ends up in
    always_comb
    begin
        evict    = 1'b0;
        page_we  = 1'b0;
        if (found_reg)
        begin
            used_idx = hit_idx_reg;
        end
        else if (!full)
        begin
            used_idx = filled_reg[IDX_W-1:0];
            page_we  = finish;
        end
        else
        begin
            used_idx = min_idx_reg;
            evict    = 1'b1;
            page_we  = finish;
        end
    end

    // frame store: written when the result is formed, read once per scan cycle
    always_ff @(posedge clk)
    begin
        if (page_we)
        begin
            pages_mem[used_idx] <= page_reg;
        end
        if (finish)
        begin
            stamps_mem[used_idx] <= time_reg;
        end
        if (state_reg == ST_SCAN)
        begin
            rd_page_reg  <= pages_mem[issue_reg];
            rd_stamp_reg <= stamps_mem[issue_reg];
        end
    end

    // sequencer, scan bookkeeping and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            page_reg          <= '0;
            time_reg          <= '0;
            fault_reg         <= '0;
            filled_reg        <= '0;
            issue_reg         <= '0;
            cmp_vld_reg       <= 1'b0;
            cmp_idx_reg       <= '0;
            found_reg         <= 1'b0;
            hit_idx_reg       <= '0;
            min_stamp_reg     <= '0;
            min_idx_reg       <= '0;
            min_page_reg      <= '0;
            done_reg          <= 1'b0;
            hit_reg           <= 1'b0;
            frame_index_reg   <= '0;
            evicted_valid_reg <= 1'b0;
            evicted_page_reg  <= '0;
        end
        else
        begin
            done_reg    <= 1'b0;
            cmp_vld_reg <= (state_reg == ST_SCAN);
            cmp_idx_reg <= issue_reg;

            // compare stage runs whenever read data is in flight
            if (match)
            begin
                found_reg   <= 1'b1;
                hit_idx_reg <= cmp_idx_reg;
            end
            if (new_min)
            begin
                min_stamp_reg <= rd_stamp_reg;
                min_idx_reg   <= cmp_idx_reg;
                min_page_reg  <= rd_page_reg;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        page_reg  <= page;
                        time_reg  <= time_next;
                        issue_reg <= '0;
                        found_reg <= 1'b0;
                        state_reg <= (filled_reg == '0) ? ST_FINISH : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (last_issue)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        issue_reg <= issue_reg + idx_t'(1);
                    end
                end
                ST_DRAIN:
                begin
                    // last compare completes on this edge
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    done_reg          <= 1'b1;
                    hit_reg           <= found_reg;
                    frame_index_reg   <= lpr_pkg::frame_idx_t'(used_idx);
                    evicted_valid_reg <= evict;
                    evicted_page_reg  <= evict ? min_page_reg : '0;
                    if (!found_reg)
                    begin
                        fault_reg <= fault_reg + lpr_pkg::fault_t'(1);
                        if (!full)
                        begin
                            filled_reg <= filled_reg + cnt_t'(1);
                        end
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_total   = fault_reg;

endmodule

@@ hdl/lpr_checker.sv @@
`timescale 1ns / 1ps

module lpr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic                hit,
    input logic                evicted_valid,
    input lpr_pkg::page_t      evicted_page,
    input lpr_pkg::fault_t     fault_total
);

    // an accepted reference keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted reference did not make the block busy");

    // a result transfer only shows while new references may be taken
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    // hits never evict
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (!evicted_valid && (evicted_page == '0)))
        else $error("hit reported an eviction");

    // a fault adds one to the running total as the result appears
    a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (fault_total == ($past(fault_total) + lpr_pkg::fault_t'(1))))
        else $error("fault total did not step on a fault");

    // the total only moves together with a result
    a_fault_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable(fault_total))
        else $error("fault total changed without a result");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
);
